// ===== src/tks_pkg.sv =====
// ----------------------------------------------------------------------------
// tks_pkg
// Shared codes, formats and controller/datapath interface types for the
// touch kinetic scroller.
// ----------------------------------------------------------------------------
`default_nettype none

package tks_pkg;

	localparam logic [1:0] OP_PRESS   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_MOVE    = 2'd2;
	localparam logic [1:0] OP_TICK    = 2'd3;

	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_WAIT   = 2'd1;
	localparam logic [1:0] MODE_SCROLL = 2'd2;
	localparam logic [1:0] MODE_KIN    = 2'd3;

	localparam logic [1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [1:0] CFG_GAIN      = 2'd1;
	localparam logic [1:0] CFG_FRAME     = 2'd2;
	localparam logic [1:0] CFG_DECEL     = 2'd3;

	localparam int CFG_W   = 24;
	localparam int VEL_W   = 32;
	localparam int SPEED_W = 32;
	localparam int DIR_W   = 16;
	localparam int DIR_FRAC = 14;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_WCMP,
		S_MSQ,
		S_SQRT_GO,
		S_SQRT_RUN,
		S_DIV_GO,
		S_DIV_RUN,
		S_REL_FIN,
		S_TICK_MUL2,
		S_TICK_FIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic       cap;
		logic       press;
		logic       clr_res;
		logic       wsq;
		logic       move;
		logic       from_origin;
		logic       msq;
		logic       sqrt_start;
		logic       sqrt_take;
		logic       div_start;
		logic       div_take;
		logic       rel_fin;
		logic       tick_mul;
		logic       tick_mul2;
		logic       tick_fin;
		logic       tick_low;
		logic       out_load;
		logic [1:0] idx;
		logic       comp;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] mode;
		logic       thr_ok;
		logic       speed_ok;
		logic       m0_zero;
		logic       sqrt_busy;
		logic       div_busy;
	} status_t;

endpackage

`default_nettype wire

// ===== src/tks_isqrt.sv =====
// ----------------------------------------------------------------------------
// tks_isqrt
// Bit-pair iterative integer square root of a 64-bit value, one result bit
// per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_isqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] radicand,
	output logic             busy,
	output logic [31:0]      root
);

	logic        busy_q;
	logic [63:0] n_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [63:0] trial;
	logic        ge;

	assign trial = res_q + bit_q;
	assign ge    = (n_q >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && bit_q[0]) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= radicand;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (ge) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = res_q[31:0];

endmodule

`default_nettype wire

// ===== src/tks_div.sv =====
// ----------------------------------------------------------------------------
// tks_div
// Restoring unsigned divider, one numerator bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_div #(
	parameter int NUM_W = 46,
	parameter int DEN_W = 32,
	parameter int QUO_W = 15
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  busy,
	output logic [QUO_W-1:0]      quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [DEN_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

// ===== src/tks_datapath.sv =====
// ----------------------------------------------------------------------------
// tks_datapath
// Gesture state, configuration registers, arithmetic and result registers
// of the touch kinetic scroller.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_datapath #(
	parameter int CB = 16,
	parameter int FB = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire tks_pkg::cmd_t             cmd,
	output tks_pkg::status_t               status,
	input  wire logic                      cfg_we,
	input  wire logic [1:0]                cfg_index,
	input  wire logic [tks_pkg::CFG_W-1:0] cfg_data,
	input  wire logic [1:0]                operation,
	input  wire logic signed [CB-1:0]      pos_x,
	input  wire logic signed [CB-1:0]      pos_y,
	output logic signed [CB:0]             delta_x,
	output logic signed [CB:0]             delta_y,
	output logic                           kinetic_valid,
	output logic [1:0]                     mode
);

	localparam int VW  = tks_pkg::VEL_W;
	localparam int SW  = tks_pkg::SPEED_W;
	localparam int MW  = CB + 1 + 16 + 8;
	localparam int SHL = (FB >= 8) ? FB - 8 : 0;
	localparam int SHR = (FB < 8) ? 8 - FB : 0;
	localparam int D2W = (2 * CB + 3 > 20) ? 2 * CB + 3 : 20;
	localparam int TSH = FB + 30;
	localparam int DSH = 24 - FB;
	localparam logic [SW-1:0] SPEED_MIN = SW'(((64'd1 << FB) + 64'd999) / 64'd1000);
	localparam logic [62:0] LIM_POS = (63'd1 << CB) - 63'd1;
	localparam logic [62:0] LIM_NEG = (63'd1 << CB);

	logic [1:0]           op_q;
	logic signed [CB-1:0] px_q, py_q;
	logic [1:0]           mode_q;
	logic signed [CB-1:0] org_x_q, org_y_q, last_x_q, last_y_q;
	logic signed [VW-1:0] hist_x_q [3];
	logic signed [VW-1:0] hist_y_q [3];
	logic [SW-1:0]        speed_q, best_q, m0_q;
	logic signed [tks_pkg::DIR_W-1:0] dir_x_q, dir_y_q;

	logic [9:0]  thr_q;
	logic [15:0] gain_q, ft_q;
	logic [23:0] dec_q;

	logic signed [CB:0] res_dx_q, res_dy_q;
	logic               res_kv_q;
	logic signed [CB:0] out_dx_q, out_dy_q;
	logic               out_kv_q;
	logic [1:0]         out_mode_q;

	logic [2*CB+1:0] wsqx_s1, wsqy_s1;
	logic [19:0]     thr_sq_s1;
	logic [63:0]     sqx_s1, sqy_s1;
	logic [47:0]     base_s1;
	logic [39:0]     decp_s1;
	logic [62:0]     prodx_s2, prody_s2;

	logic signed [CB:0]   wdx, wdy, mdx, mdy;
	logic signed [CB-1:0] ref_x, ref_y;
	logic signed [VW-1:0] hx_sel, hy_sel, h0_sel;
	logic [VW-1:0]        ax_sel, ay_sel, a0_sel;
	logic [63:0]          radicand;
	logic                 sqrt_busy, div_busy;
	logic [31:0]          root;
	logic [14:0]          quo;
	logic [14:0]          dax, day;
	logic [39:0]          dec_amt;
	logic [62:0]          tmx, tmy;
	logic [CB:0]          tcx, tcy;

	function automatic logic [VW-1:0] abs_v(input logic signed [VW-1:0] v);
		return v[VW-1] ? VW'(-v) : v;
	endfunction

	function automatic logic signed [VW-1:0] vel_of(input logic signed [CB:0] d,
		input logic [15:0] g);
		logic [CB:0]   a;
		logic [MW-1:0] m;
		a = d[CB] ? (CB+1)'(-d) : d;
		m = MW'(a) * MW'(g);
		m = (m << SHL) >> SHR;
		if (m > MW'(64'h8000_0000)) begin
			m = MW'(64'h8000_0000);
		end
		if (d[CB]) begin
			return VW'(-m[VW-1:0]);
		end
		return (m > MW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : m[VW-1:0];
	endfunction

	function automatic logic [CB:0] cap_mag(input logic [62:0] m, input logic neg);
		logic [62:0] lim;
		lim = neg ? LIM_NEG : LIM_POS;
		return (m > lim) ? lim[CB:0] : m[CB:0];
	endfunction

	assign wdx   = (CB+1)'(org_x_q) - (CB+1)'(px_q);
	assign wdy   = (CB+1)'(org_y_q) - (CB+1)'(py_q);
	assign ref_x = cmd.from_origin ? org_x_q : last_x_q;
	assign ref_y = cmd.from_origin ? org_y_q : last_y_q;
	assign mdx   = (CB+1)'(ref_x) - (CB+1)'(px_q);
	assign mdy   = (CB+1)'(ref_y) - (CB+1)'(py_q);

	assign hx_sel   = hist_x_q[cmd.idx];
	assign hy_sel   = hist_y_q[cmd.idx];
	assign ax_sel   = abs_v(hx_sel);
	assign ay_sel   = abs_v(hy_sel);
	assign h0_sel   = cmd.comp ? hist_y_q[0] : hist_x_q[0];
	assign a0_sel   = abs_v(h0_sel);
	assign radicand = sqx_s1 + sqy_s1;

	assign dax     = dir_x_q[15] ? 15'(-dir_x_q) : dir_x_q[14:0];
	assign day     = dir_y_q[15] ? 15'(-dir_y_q) : dir_y_q[14:0];
	assign dec_amt = decp_s1 >> DSH;
	assign tmx     = prodx_s2 >> TSH;
	assign tmy     = prody_s2 >> TSH;
	assign tcx     = cap_mag(tmx, dir_x_q[15]);
	assign tcy     = cap_mag(tmy, dir_y_q[15]);

	tks_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (radicand),
		.busy     (sqrt_busy),
		.root     (root)
	);

	tks_div #(
		.NUM_W (VW + tks_pkg::DIR_FRAC),
		.DEN_W (SW),
		.QUO_W (15)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    ({a0_sel, {tks_pkg::DIR_FRAC{1'b0}}}),
		.den    (m0_q),
		.busy   (div_busy),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= 10'd16;
			gain_q <= 16'd256;
			ft_q   <= 16'd1092;
			dec_q  <= 24'd256000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tks_pkg::CFG_THRESHOLD: thr_q  <= cfg_data[9:0];
				tks_pkg::CFG_GAIN:      gain_q <= cfg_data[15:0];
				tks_pkg::CFG_FRAME:     ft_q   <= cfg_data[15:0];
				tks_pkg::CFG_DECEL:     dec_q  <= cfg_data[23:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= tks_pkg::MODE_IDLE;
			org_x_q  <= '0;
			org_y_q  <= '0;
			last_x_q <= '0;
			last_y_q <= '0;
			hist_x_q <= '{default: '0};
			hist_y_q <= '{default: '0};
			speed_q  <= '0;
			dir_x_q  <= '0;
			dir_y_q  <= '0;
		end else begin
			if (cmd.press) begin
				org_x_q <= px_q;
				org_y_q <= py_q;
				mode_q  <= tks_pkg::MODE_WAIT;
			end
			if (cmd.move) begin
				hist_x_q[2] <= cmd.from_origin ? '0 : hist_x_q[1];
				hist_y_q[2] <= cmd.from_origin ? '0 : hist_y_q[1];
				hist_x_q[1] <= cmd.from_origin ? '0 : hist_x_q[0];
				hist_y_q[1] <= cmd.from_origin ? '0 : hist_y_q[0];
				hist_x_q[0] <= vel_of(mdx, gain_q);
				hist_y_q[0] <= vel_of(mdy, gain_q);
				last_x_q    <= px_q;
				last_y_q    <= py_q;
				mode_q      <= tks_pkg::MODE_SCROLL;
			end
			if (cmd.div_take) begin
				if (cmd.comp) begin
					dir_y_q <= hist_y_q[0][VW-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
				end else begin
					dir_x_q <= hist_x_q[0][VW-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
				end
			end
			if (cmd.rel_fin) begin
				speed_q <= best_q;
				mode_q  <= tks_pkg::MODE_KIN;
				if (m0_q == '0) begin
					dir_x_q <= '0;
					dir_y_q <= '0;
				end
			end
			if (cmd.tick_fin) begin
				speed_q <= (dec_amt >= 40'(speed_q)) ? '0 : SW'(40'(speed_q) - dec_amt);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q <= operation;
			px_q <= pos_x;
			py_q <= pos_y;
		end
		if (cmd.wsq) begin
			wsqx_s1   <= $unsigned((2*CB+2)'(wdx) * (2*CB+2)'(wdx));
			wsqy_s1   <= $unsigned((2*CB+2)'(wdy) * (2*CB+2)'(wdy));
			thr_sq_s1 <= 20'(thr_q) * 20'(thr_q);
		end
		if (cmd.msq) begin
			sqx_s1 <= 64'(ax_sel) * 64'(ax_sel);
			sqy_s1 <= 64'(ay_sel) * 64'(ay_sel);
		end
		if (cmd.sqrt_take) begin
			if (cmd.idx == 2'd0) begin
				m0_q   <= root;
				best_q <= root;
			end else if (root > best_q) begin
				best_q <= root;
			end
		end
		if (cmd.tick_mul) begin
			base_s1 <= 48'(speed_q) * 48'(ft_q);
			decp_s1 <= 40'(ft_q) * 40'(dec_q);
		end
		if (cmd.tick_mul2) begin
			prodx_s2 <= 63'(base_s1) * 63'(dax);
			prody_s2 <= 63'(base_s1) * 63'(day);
		end
		if (cmd.move) begin
			res_dx_q <= mdx;
			res_dy_q <= mdy;
			res_kv_q <= 1'b0;
		end else if (cmd.tick_fin) begin
			res_dx_q <= dir_x_q[15] ? (CB+1)'(-tcx) : tcx;
			res_dy_q <= dir_y_q[15] ? (CB+1)'(-tcy) : tcy;
			res_kv_q <= 1'b1;
		end else if (cmd.tick_low) begin
			res_dx_q <= '0;
			res_dy_q <= '0;
			res_kv_q <= 1'b1;
		end else if (cmd.clr_res || cmd.press || cmd.rel_fin) begin
			res_dx_q <= '0;
			res_dy_q <= '0;
			res_kv_q <= 1'b0;
		end
		if (cmd.out_load) begin
			out_dx_q   <= res_dx_q;
			out_dy_q   <= res_dy_q;
			out_kv_q   <= res_kv_q;
			out_mode_q <= mode_q;
		end
	end

	assign status.op        = op_q;
	assign status.mode      = mode_q;
	assign status.thr_ok    = (D2W'(wsqx_s1) + D2W'(wsqy_s1)) >= D2W'(thr_sq_s1);
	assign status.speed_ok  = (speed_q >= SPEED_MIN);
	assign status.m0_zero   = (m0_q == '0);
	assign status.sqrt_busy = sqrt_busy;
	assign status.div_busy  = div_busy;

	assign delta_x       = out_dx_q;
	assign delta_y       = out_dy_q;
	assign kinetic_valid = out_kv_q;
	assign mode          = out_mode_q;

endmodule

`default_nettype wire

// ===== src/tks_ctrl.sv =====
// ----------------------------------------------------------------------------
// tks_ctrl
// Sequencer of the touch kinetic scroller: decodes each transaction and
// steps the datapath through it, then hands the result to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire logic             out_stall,
	input  wire tks_pkg::status_t status,
	output tks_pkg::cmd_t         cmd
);

	tks_pkg::state_t state_q, state_d;
	logic [1:0]      idx_q, idx_d;
	logic            comp_q, comp_d;
	logic            out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tks_pkg::S_IDLE;
			idx_q       <= '0;
			comp_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			comp_q      <= comp_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		comp_d      = comp_q;
		out_valid_d = out_valid_q && out_stall;
		cmd         = '0;
		cmd.idx     = idx_q;
		cmd.comp    = comp_q;
		unique case (state_q)
			tks_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = tks_pkg::S_DISPATCH;
				end
			end
			tks_pkg::S_DISPATCH: begin
				state_d = tks_pkg::S_DONE;
				unique case (status.op)
					tks_pkg::OP_PRESS: cmd.press = 1'b1;
					tks_pkg::OP_RELEASE: begin
						if (status.mode == tks_pkg::MODE_SCROLL) begin
							idx_d   = 2'd0;
							state_d = tks_pkg::S_MSQ;
						end else begin
							cmd.clr_res = 1'b1;
						end
					end
					tks_pkg::OP_MOVE: begin
						if (status.mode == tks_pkg::MODE_WAIT) begin
							cmd.wsq = 1'b1;
							state_d = tks_pkg::S_WCMP;
						end else if (status.mode == tks_pkg::MODE_SCROLL) begin
							cmd.move = 1'b1;
						end else begin
							cmd.clr_res = 1'b1;
						end
					end
					tks_pkg::OP_TICK: begin
						if (status.mode != tks_pkg::MODE_KIN) begin
							cmd.clr_res = 1'b1;
						end else if (status.speed_ok) begin
							cmd.tick_mul = 1'b1;
							state_d      = tks_pkg::S_TICK_MUL2;
						end else begin
							cmd.tick_low = 1'b1;
						end
					end
				endcase
			end
			tks_pkg::S_WCMP: begin
				if (status.thr_ok) begin
					cmd.move        = 1'b1;
					cmd.from_origin = 1'b1;
				end else begin
					cmd.clr_res = 1'b1;
				end
				state_d = tks_pkg::S_DONE;
			end
			tks_pkg::S_MSQ: begin
				cmd.msq = 1'b1;
				state_d = tks_pkg::S_SQRT_GO;
			end
			tks_pkg::S_SQRT_GO: begin
				cmd.sqrt_start = 1'b1;
				state_d        = tks_pkg::S_SQRT_RUN;
			end
			tks_pkg::S_SQRT_RUN: begin
				if (!status.sqrt_busy) begin
					cmd.sqrt_take = 1'b1;
					if (idx_q == 2'd2) begin
						comp_d  = 1'b0;
						state_d = status.m0_zero ? tks_pkg::S_REL_FIN : tks_pkg::S_DIV_GO;
					end else begin
						idx_d   = idx_q + 2'd1;
						state_d = tks_pkg::S_MSQ;
					end
				end
			end
			tks_pkg::S_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = tks_pkg::S_DIV_RUN;
			end
			tks_pkg::S_DIV_RUN: begin
				if (!status.div_busy) begin
					cmd.div_take = 1'b1;
					if (comp_q) begin
						state_d = tks_pkg::S_REL_FIN;
					end else begin
						comp_d  = 1'b1;
						state_d = tks_pkg::S_DIV_GO;
					end
				end
			end
			tks_pkg::S_REL_FIN: begin
				cmd.rel_fin = 1'b1;
				state_d     = tks_pkg::S_DONE;
			end
			tks_pkg::S_TICK_MUL2: begin
				cmd.tick_mul2 = 1'b1;
				state_d       = tks_pkg::S_TICK_FIN;
			end
			tks_pkg::S_TICK_FIN: begin
				cmd.tick_fin = 1'b1;
				state_d      = tks_pkg::S_DONE;
			end
			tks_pkg::S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = tks_pkg::S_IDLE;
				end
			end
			default: state_d = tks_pkg::S_IDLE;
		endcase
	end

	assign in_stall  = (state_q != tks_pkg::S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== src/touch_kinetic_scroller_unit.sv =====
// Work per transaction: a release in scrolling mode runs three square roots and two
// divisions, and skips the divisions with zero last velocity; a waiting move adds a
// threshold compare; a kinetic tick steps through S_TICK_MUL2 and S_TICK_FIN.
// One transaction in flight; a new one is accepted while the result waits.
// Reset (arst_n low, asynchronous) returns to idle mode with cleared state
// and the default configuration.
// ----------------------------------------------------------------------------
// touch_kinetic_scroller_unit
// Touch scroll gesture engine: idle/wait/scroll/fling modes with kinetic
// decay driven by frame ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_kinetic_scroller_unit #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [1:0]                operation,
	input  wire logic signed [COORD_BITS-1:0] pos_x,
	input  wire logic signed [COORD_BITS-1:0] pos_y,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic signed [COORD_BITS:0]     delta_x,
	output logic signed [COORD_BITS:0]     delta_y,
	output logic                           kinetic_valid,
	output logic [1:0]                     mode,
	input  wire logic                      cfg_we,
	input  wire logic [1:0]                cfg_index,
	input  wire logic [tks_pkg::CFG_W-1:0] cfg_data
);

	tks_pkg::cmd_t    cmd;
	tks_pkg::status_t status;

	tks_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	tks_datapath #(
		.CB (COORD_BITS),
		.FB (FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.operation     (operation),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.delta_x       (delta_x),
		.delta_y       (delta_y),
		.kinetic_valid (kinetic_valid),
		.mode          (mode)
	);

endmodule

`default_nettype wire

// ===== src/tks_checker.sv =====
// ----------------------------------------------------------------------------
// tks_checker
// Port-level checks of the touch kinetic scroller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_checker #(
	parameter int COORD_BITS = 16
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic [COORD_BITS:0]   delta_x,
	input wire logic [COORD_BITS:0]   delta_y,
	input wire logic                  kinetic_valid,
	input wire logic [1:0]            mode
);

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(delta_x) && $stable(delta_y)
			&& $stable(mode) && $stable(kinetic_valid))
		else $error("stalled transaction changed");

	a_kin_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kinetic_valid |-> mode == tks_pkg::MODE_KIN)
		else $error("kinetic result outside kinetic mode");

	a_zero_delta: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kinetic_valid && mode != tks_pkg::MODE_SCROLL
			|-> delta_x == '0 && delta_y == '0)
		else $error("nonzero delta outside scrolling and kinetic tick");

endmodule

bind touch_kinetic_scroller_unit tks_checker #(.COORD_BITS(COORD_BITS)) u_tks_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.delta_x       (delta_x),
	.delta_y       (delta_y),
	.kinetic_valid (kinetic_valid),
	.mode          (mode)
);

`default_nettype wire
